// ===== design/maze_pkg.sv =====
// Package for the maze carver: grid constants, item codes, cell type and helpers.
package maze_pkg;

    localparam int GRID_W = 16;
    localparam int GRID_H = 16;
    localparam int NCELLS = GRID_W * GRID_H;
    localparam int X_W    = $clog2(GRID_W);
    localparam int Y_W    = $clog2(GRID_H);
    localparam int CELL_W = $clog2(NCELLS);
    localparam int CNT_W  = $clog2(NCELLS + 1);
    localparam int RND_W  = 16;
    localparam int POS_W  = 4;

    typedef enum logic [1:0] {
        EV_CARVE    = 2'd0,
        EV_ENTRANCE = 2'd1,
        EV_EXIT     = 2'd2,
        EV_IDLE     = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_TOP    = 2'd1,
        SIDE_RIGHT  = 2'd2,
        SIDE_BOTTOM = 2'd3
    } side_t;

    typedef enum logic {
        KIND_START   = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [Y_W-1:0] y;
        logic [X_W-1:0] x;
    } cell_t;

    // Neighbours are examined left, right, up, down.
    function automatic side_t scan_side(input logic [1:0] k);
        side_t s;
        case (k)
            2'd0:    s = SIDE_LEFT;
            2'd1:    s = SIDE_RIGHT;
            2'd2:    s = SIDE_TOP;
            default: s = SIDE_BOTTOM;
        endcase
        return s;
    endfunction

    function automatic logic in_grid(input cell_t c, input side_t s);
        logic ok;
        case (s)
            SIDE_LEFT:  ok = (c.x != '0);
            SIDE_RIGHT: ok = (c.x != X_W'(GRID_W - 1));
            SIDE_TOP:   ok = (c.y != Y_W'(GRID_H - 1));
            default:    ok = (c.y != '0);
        endcase
        return ok;
    endfunction

    // Up is y+1 and removes the top wall; down is y-1 and removes the bottom wall.
    function automatic cell_t step_cell(input cell_t c, input side_t s);
        cell_t n;
        n = c;
        case (s)
            SIDE_LEFT:  n.x = c.x - X_W'(1);
            SIDE_RIGHT: n.x = c.x + X_W'(1);
            SIDE_TOP:   n.y = c.y + Y_W'(1);
            default:    n.y = c.y - Y_W'(1);
        endcase
        return n;
    endfunction

    function automatic logic [CELL_W-1:0] cell_addr(input cell_t c);
        return CELL_W'(c.y) * CELL_W'(GRID_W) + CELL_W'(c.x);
    endfunction

    // Since 4 is 1 modulo 3, the base-4 digit sum keeps the residue; fold it twice.
    function automatic logic [1:0] mod3_u16(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [3:0] f1;
        logic [2:0] f2;
        logic [1:0] r;
        s = '0;
        for (int i = 0; i < RND_W / 2; i++)
        begin
            s = s + 5'(v[2*i +: 2]);
        end
        f1 = 4'(s[4:2]) + 4'(s[1:0]);
        f2 = 3'(f1[3:2]) + 3'(f1[1:0]);
        if (f2 >= 3'd3)
        begin
            f2 = f2 - 3'd3;
        end
        r = f2[1:0];
        return r;
    endfunction

endpackage

// ===== design/maze_ifs.sv =====
// Handshake channels of the maze carver: the command item and the result item.
interface maze_cmd_if;
    import maze_pkg::*;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [RND_W-1:0] random_value;

    modport source (output valid, output kind, output random_value, input ready);
    modport sink   (input valid, input kind, input random_value, output ready);
endinterface

interface maze_res_if;
    import maze_pkg::*;
    logic             valid;
    logic             ready;
    event_t           event_res;
    logic [POS_W-1:0] cell_x;
    logic [POS_W-1:0] cell_y;
    side_t            side;

    modport source (output valid, output event_res, output cell_x, output cell_y,
                    output side, input ready);
    modport sink   (input valid, input event_res, input cell_x, input cell_y,
                    input side, output ready);
endinterface

// ===== design/maze_carver_unit.sv =====
// Maze carver top level: depth-first carving sequencer with its cell stack and visited map.
//
// Each command item yields exactly one result item. A start item passes through the
// accepting step, a clearing pass that writes one entry of the visited map per cycle
// (marking cell (0,0) on the way), and the emit step. An advance item that finds the
// stack empty passes through the accepting, fetch and emit steps; otherwise every stack
// cell examined (the cells popped plus the one that is carved from) costs one stack read,
// a scan in which a single neighbour checker issues four visited-map reads and tests each
// registered answer, and one step to pick or pop. The emit step waits while the output
// register still holds a result that has not been taken. The block takes no command
// while an item is in progress; a finished result waits in the output register without
// holding up the next command. The visited map holds no defined contents until the first
// start, which is harmless because the block only reports idle before then.
module maze_carver_unit
    import maze_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    maze_cmd_if.sink   cmd,
    maze_res_if.source res
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   exit_rep_reg, exit_rep_next;
    logic                   out_valid_reg, out_valid_next;

    logic [RND_W-1:0]       rnd_reg, rnd_next;
    logic [1:0]             mod3_reg, mod3_next;
    logic [2:0]             scan_reg, scan_next;
    logic [2:0]             cand_cnt_reg, cand_cnt_next;
    side_t                  cand_side_reg [4];
    side_t                  cand_side_next [4];
    logic [CELL_W-1:0]      clr_reg, clr_next;
    logic                   look_ok_reg, look_ok_next;
    side_t                  look_side_reg, look_side_next;
    event_t                 res_event_reg, res_event_next;
    logic [POS_W-1:0]       res_x_reg, res_x_next;
    logic [POS_W-1:0]       res_y_reg, res_y_next;
    side_t                  res_side_reg, res_side_next;
    event_t                 out_event_reg, out_event_next;
    logic [POS_W-1:0]       out_x_reg, out_x_next;
    logic [POS_W-1:0]       out_y_reg, out_y_next;
    side_t                  out_side_reg, out_side_next;

    cell_t                  stack_reg [NCELLS];
    cell_t                  stack_rd_reg;
    logic                   stack_we;
    logic [CELL_W-1:0]      stack_wa;
    cell_t                  stack_wd;
    logic                   stack_re;
    logic [CELL_W-1:0]      stack_ra;

    logic                   vis_mem [NCELLS];
    logic                   vis_rd_reg;
    logic                   vis_we;
    logic [CELL_W-1:0]      vis_wa;
    logic                   vis_wd;
    logic                   vis_re;
    logic [CELL_W-1:0]      vis_ra;

    side_t                  scan_s;
    cell_t                  scan_nb;
    logic [1:0]             pick_idx;
    side_t                  pick_s;
    cell_t                  pick_nb;
    logic [CNT_W-1:0]       count_dec;

    assign cmd.ready     = (state_reg == ST_IDLE);
    assign res.valid     = out_valid_reg;
    assign res.event_res = out_event_reg;
    assign res.cell_x    = out_x_reg;
    assign res.cell_y    = out_y_reg;
    assign res.side      = out_side_reg;

    // Cell stack: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_reg[stack_wa] <= stack_wd;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_reg[stack_ra];
        end
    end

    // Visited map: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_wa] <= vis_wd;
        end
        if (vis_re)
        begin
            vis_rd_reg <= vis_mem[vis_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            exit_rep_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            exit_rep_reg  <= exit_rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg       <= rnd_next;
        mod3_reg      <= mod3_next;
        scan_reg      <= scan_next;
        cand_cnt_reg  <= cand_cnt_next;
        cand_side_reg <= cand_side_next;
        clr_reg       <= clr_next;
        look_ok_reg   <= look_ok_next;
        look_side_reg <= look_side_next;
        res_event_reg <= res_event_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_side_reg  <= res_side_next;
        out_event_reg <= out_event_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_side_reg  <= out_side_next;
    end

    // The shared neighbour checker: one neighbour of the top cell per cycle.
    assign scan_s  = scan_side(scan_reg[1:0]);
    assign scan_nb = step_cell(stack_rd_reg, scan_s);

    always_comb
    begin
        case (cand_cnt_reg)
            3'd1:    pick_idx = 2'd0;
            3'd2:    pick_idx = {1'b0, rnd_reg[0]};
            3'd3:    pick_idx = mod3_reg;
            default: pick_idx = rnd_reg[1:0];
        endcase
    end

    assign pick_s    = cand_side_reg[pick_idx];
    assign pick_nb   = step_cell(stack_rd_reg, pick_s);
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        exit_rep_next  = exit_rep_reg;
        out_valid_next = out_valid_reg;
        rnd_next       = rnd_reg;
        mod3_next      = mod3_reg;
        scan_next      = scan_reg;
        cand_cnt_next  = cand_cnt_reg;
        cand_side_next = cand_side_reg;
        clr_next       = clr_reg;
        look_ok_next   = look_ok_reg;
        look_side_next = look_side_reg;
        res_event_next = res_event_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_side_next  = res_side_reg;
        out_event_next = out_event_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_side_next  = out_side_reg;
        stack_we       = 1'b0;
        stack_wa       = '0;
        stack_wd       = '0;
        stack_re       = 1'b0;
        stack_ra       = '0;
        vis_we         = 1'b0;
        vis_wa         = '0;
        vis_wd         = 1'b0;
        vis_re         = 1'b0;
        vis_ra         = '0;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.kind == KIND_START)
                    begin
                        stack_we        = 1'b1;
                        stack_wa        = '0;
                        stack_wd        = '0;
                        count_next      = CNT_W'(1);
                        exit_rep_next   = 1'b0;
                        res_event_next  = EV_ENTRANCE;
                        res_x_next      = '0;
                        res_y_next      = '0;
                        res_side_next   = SIDE_BOTTOM;
                        clr_next        = '0;
                        state_next      = ST_CLEAR;
                    end
                    else
                    begin
                        rnd_next   = cmd.random_value;
                        mod3_next  = mod3_u16(cmd.random_value);
                        state_next = ST_FETCH;
                    end
                end
            end

            // Clears the visited map one entry per cycle; cell (0,0) is left visited.
            ST_CLEAR:
            begin
                vis_we   = 1'b1;
                vis_wa   = clr_reg;
                vis_wd   = (clr_reg == '0);
                clr_next = clr_reg + CELL_W'(1);
                if (clr_reg == CELL_W'(NCELLS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_FETCH:
            begin
                if (count_reg == '0)
                begin
                    res_event_next = exit_rep_reg ? EV_IDLE : EV_EXIT;
                    res_x_next     = exit_rep_reg ? '0 : POS_W'(GRID_W - 1);
                    res_y_next     = exit_rep_reg ? '0 : POS_W'(GRID_H - 1);
                    res_side_next  = exit_rep_reg ? SIDE_LEFT : SIDE_TOP;
                    exit_rep_next  = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    stack_re      = 1'b1;
                    stack_ra      = count_dec[CELL_W-1:0];
                    scan_next     = '0;
                    cand_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end

            // Each step issues the read for one neighbour and tests the answer to the
            // read issued in the step before.
            ST_SCAN:
            begin
                if (scan_reg != 3'd0 && look_ok_reg && !vis_rd_reg)
                begin
                    cand_side_next[cand_cnt_reg[1:0]] = look_side_reg;
                    cand_cnt_next = cand_cnt_reg + 3'd1;
                end
                if (scan_reg == 3'd4)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    vis_re         = 1'b1;
                    vis_ra         = cell_addr(scan_nb);
                    look_ok_next   = in_grid(stack_rd_reg, scan_s);
                    look_side_next = scan_s;
                    scan_next      = scan_reg + 3'd1;
                end
            end

            ST_PICK:
            begin
                if (cand_cnt_reg == '0)
                begin
                    count_next = count_dec;
                    state_next = ST_FETCH;
                end
                else
                begin
                    vis_we = 1'b1;
                    vis_wa = cell_addr(pick_nb);
                    vis_wd = 1'b1;
                    if (count_reg < CNT_W'(NCELLS))
                    begin
                        stack_we   = 1'b1;
                        stack_wa   = count_reg[CELL_W-1:0];
                        stack_wd   = pick_nb;
                        count_next = count_reg + CNT_W'(1);
                    end
                    res_event_next = EV_CARVE;
                    res_x_next     = POS_W'(stack_rd_reg.x);
                    res_y_next     = POS_W'(stack_rd_reg.y);
                    res_side_next  = pick_s;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = res_event_reg;
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_side_next  = res_side_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg != ST_IDLE))
        else $error("command item accepted but sequencer stayed idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NCELLS))
        else $error("stack count beyond the number of cells");

    a_clear_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_reg == CELL_W'(NCELLS - 1)) |=> (state_reg == ST_EMIT))
        else $error("clearing pass did not end in the emit step");

    a_carve_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK && cand_cnt_reg != '0 && count_reg < CNT_W'(NCELLS))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("carved cell was not pushed onto the stack");

    a_scan_to_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_reg == 3'd4) |=> (state_reg == ST_PICK))
        else $error("neighbour scan did not end in the pick step");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the maze carver: directed and random command items.
module tb_top
    import maze_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TOTAL_ITEMS = 450;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN       = 32;

    typedef struct packed {
        event_t           ev;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        side_t            side;
    } carve_res_t;

    // Tracks the depth-first walk and compares the block's reports against it.
    class maze_scoreboard;
        bit         visited [NCELLS];
        int         walk_stack [NCELLS];
        int         depth;
        bit         exit_done;
        carve_res_t pending_results [$];
        int         mismatches;

        function new();
            foreach (visited[i])
                visited[i] = 1'b0;
            depth      = 0;
            exit_done  = 1'b1;
            mismatches = 0;
        endfunction

        function carve_res_t carve_step(kind_t k, logic [RND_W-1:0] rv);
            carve_res_t r;
            int         c, x, y, n, pick, nc;
            int         cx [4];
            int         cy [4];
            side_t      cs [4];
            r.ev   = EV_IDLE;
            r.x    = '0;
            r.y    = '0;
            r.side = SIDE_LEFT;
            if (k == KIND_START)
            begin
                foreach (visited[i])
                    visited[i] = 1'b0;
                visited[0]    = 1'b1;
                walk_stack[0] = 0;
                depth         = 1;
                exit_done     = 1'b0;
                r.ev   = EV_ENTRANCE;
                r.side = SIDE_BOTTOM;
                return r;
            end
            while (depth > 0)
            begin
                c = walk_stack[depth - 1];
                x = c % GRID_W;
                y = c / GRID_W;
                n = 0;
                if (x > 0 && !visited[y * GRID_W + x - 1])
                begin
                    cx[n] = x - 1; cy[n] = y; cs[n] = SIDE_LEFT; n++;
                end
                if (x + 1 < GRID_W && !visited[y * GRID_W + x + 1])
                begin
                    cx[n] = x + 1; cy[n] = y; cs[n] = SIDE_RIGHT; n++;
                end
                if (y + 1 < GRID_H && !visited[(y + 1) * GRID_W + x])
                begin
                    cx[n] = x; cy[n] = y + 1; cs[n] = SIDE_TOP; n++;
                end
                if (y > 0 && !visited[(y - 1) * GRID_W + x])
                begin
                    cx[n] = x; cy[n] = y - 1; cs[n] = SIDE_BOTTOM; n++;
                end
                if (n == 0)
                begin
                    depth--;
                    continue;
                end
                pick = int'(rv) % n;
                nc   = cy[pick] * GRID_W + cx[pick];
                visited[nc] = 1'b1;
                if (depth < NCELLS)
                begin
                    walk_stack[depth] = nc;
                    depth++;
                end
                r.ev   = EV_CARVE;
                r.x    = POS_W'(x);
                r.y    = POS_W'(y);
                r.side = cs[pick];
                return r;
            end
            // The walk has unwound completely: the exit is reported only once.
            if (!exit_done)
            begin
                exit_done = 1'b1;
                r.ev   = EV_EXIT;
                r.x    = POS_W'(GRID_W - 1);
                r.y    = POS_W'(GRID_H - 1);
                r.side = SIDE_TOP;
            end
            return r;
        endfunction

        function void note_command(kind_t k, logic [RND_W-1:0] rv);
            pending_results.insert(pending_results.size(), carve_step(k, rv));
        endfunction

        function void check_result(carve_res_t got);
            carve_res_t exp;
            if (pending_results.size() == 0)
            begin
                $error("result item with no command outstanding");
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.ev !== exp.ev)
            begin
                $error("event_res: expected %0d, got %0d", exp.ev, got.ev);
                mismatches++;
            end
            if (got.x !== exp.x)
            begin
                $error("cell_x: expected %0d, got %0d", exp.x, got.x);
                mismatches++;
            end
            if (got.y !== exp.y)
            begin
                $error("cell_y: expected %0d, got %0d", exp.y, got.y);
                mismatches++;
            end
            if (got.side !== exp.side)
            begin
                $error("side: expected %0d, got %0d", exp.side, got.side);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady = 1'b0;
    int   sent = 0;
    int   cycle_count = 0;

    maze_scoreboard board = new();

    maze_cmd_if cmd_if ();
    maze_res_if res_if ();

    maze_carver_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offers one command item after a random gap; valid stays high across back-to-back items.
    task automatic send_cmd(input kind_t k, input logic [RND_W-1:0] rv);
        int gap;
        if ($urandom_range(0, 31) == 0)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.kind         <= k;
        cmd_if.random_value <= rv;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        board.note_command(k, rv);
        sent++;
    endtask

    // Result side: random stalls, and one long hold-off so that the block backs up.
    initial
    begin
        int         stall;
        int         taken;
        carve_res_t got;
        res_if.ready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid)
                @(posedge clk);
            got.ev   = res_if.event_res;
            got.x    = res_if.cell_x;
            got.y    = res_if.cell_y;
            got.side = res_if.side;
            board.check_result(got);
            taken++;
        end
    end

    initial
    begin
        int n_adv;
        rst_n               = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.kind         = KIND_START;
        cmd_if.random_value = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // An advance before any start finds an empty stack and reports idle.
        send_cmd(KIND_ADVANCE, 16'h0000);
        send_cmd(KIND_ADVANCE, 16'hFFFF);
        send_cmd(KIND_START, 16'hFFFF);
        send_cmd(KIND_ADVANCE, 16'h0000);
        send_cmd(KIND_ADVANCE, 16'hFFFF);
        send_cmd(KIND_ADVANCE, 16'h0001);
        send_cmd(KIND_ADVANCE, 16'h0002);
        send_cmd(KIND_ADVANCE, 16'h0003);
        send_cmd(KIND_ADVANCE, 16'hAAAA);
        send_cmd(KIND_ADVANCE, 16'h5555);
        send_cmd(KIND_ADVANCE, 16'h8000);
        send_cmd(KIND_ADVANCE, 16'h7FFF);
        // A start in the middle of a walk abandons it.
        send_cmd(KIND_START, 16'h0000);
        send_cmd(KIND_ADVANCE, 16'h0004);
        send_cmd(KIND_ADVANCE, 16'hFFFE);
        send_cmd(KIND_START, 16'h1234);
        send_cmd(KIND_START, 16'h0000);
        send_cmd(KIND_ADVANCE, 16'h0005);

        // One complete maze: every cell carved, the exit, then idle reports.
        send_cmd(KIND_START, RND_W'($urandom_range(0, 65535)));
        repeat (NCELLS + 2)
            send_cmd(KIND_ADVANCE, RND_W'($urandom_range(0, 65535)));

        while (sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_cmd(KIND_START, RND_W'($urandom_range(0, 65535)));
                n_adv = $urandom_range(5, 40);
                repeat (n_adv)
                    send_cmd(KIND_ADVANCE, RND_W'($urandom_range(0, 65535)));
            end
            else
            begin
                n_adv = $urandom_range(1, 6);
                repeat (n_adv)
                    send_cmd(kind_t'($urandom_range(0, 1)), RND_W'($urandom_range(0, 65535)));
            end
        end
        cmd_if.valid <= 1'b0;

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
design/maze_pkg.sv
design/maze_ifs.sv
design/maze_carver_unit.sv
tb/tb_top.sv
